### rtl/pad_command_queue_with_coalescing_core_defines.svh
// Assertion macros shared by the command queue RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PAD_COMMAND_QUEUE_WITH_COALESCING_CORE_DEFINES_SVH
`define PAD_COMMAND_QUEUE_WITH_COALESCING_CORE_DEFINES_SVH
`ifndef SYNTH
`define PCQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PCQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PCQ_ASSERT(lbl, clk, rstn, prop, msg)
`define PCQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/pcq_pkg.sv
// Types, codes and mapping functions of the pad command queue.
// No dependencies; imported by the front, the command FIFO, the back and the top.
package pcq_pkg;

  localparam logic [7:0] AxisMax    = 8'hFF;
  localparam logic [7:0] AxisCenter = 8'd128;

  typedef enum logic {
    OpPush = 1'b0,
    OpPoll = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ActNothing      = 2'd0,
    ActPress        = 2'd1,
    ActRelease      = 2'd2,
    ActPressRelease = 2'd3
  } action_e;

  typedef struct packed {
    logic [7:0]  cstick_y;
    logic [7:0]  cstick_x;
    logic [7:0]  stick_y;
    logic [7:0]  stick_x;
    logic [11:0] buttons;
  } report_t;

  typedef struct packed {
    action_e action;
    report_t report;
  } entry_t;

  typedef struct packed {
    opcode_e op;
    logic    write_ok;
    action_e action;
    report_t report;
  } cmd_t;

  localparam report_t DefaultReport = '{
    cstick_y: AxisCenter,
    cstick_x: AxisCenter,
    stick_y:  AxisCenter,
    stick_x:  AxisCenter,
    buttons:  12'd0
  };

  // Direction bits: dup, ddown, dleft, dright from bit 0.
  function automatic logic [3:0] hat_dirs(input logic [3:0] hat);
    logic [3:0] dirs;
    unique case (hat)
      4'd0:    dirs = 4'h1;
      4'd1:    dirs = 4'h9;
      4'd2:    dirs = 4'h8;
      4'd3:    dirs = 4'hA;
      4'd4:    dirs = 4'h2;
      4'd5:    dirs = 4'h6;
      4'd6:    dirs = 4'h4;
      4'd7:    dirs = 4'h5;
      default: dirs = 4'h0;
    endcase
    return dirs;
  endfunction

  // Flip a vertical axis; zero is not a legal report value, so bump it to one.
  function automatic logic [7:0] invert_axis(input logic [7:0] raw);
    logic [7:0] v;
    v = AxisMax - raw;
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

### rtl/pcq_intf.sv
// Handshake interfaces of the pad command queue: input items, results, register writes.
// No dependencies.
interface pcq_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [8:0] pad_buttons;
  logic [3:0] hat;
  logic [7:0] left_x;
  logic [7:0] left_y;
  logic [7:0] right_x;
  logic [7:0] right_y;
  logic [1:0] format_index;
  logic       write_ok;

  modport source (output valid, opcode, pad_buttons, hat, left_x, left_y, right_x, right_y,
                  format_index, write_ok, input ready);
  modport sink (input valid, opcode, pad_buttons, hat, left_x, left_y, right_x, right_y,
                format_index, write_ok, output ready);
endinterface

interface pcq_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] report_buttons;
  logic [7:0]  stick_x;
  logic [7:0]  stick_y;
  logic [7:0]  cstick_x;
  logic [7:0]  cstick_y;
  logic [1:0]  reset_action;
  logic        dequeued;
  logic        coalesced;
  logic [6:0]  queue_fill;

  modport source (output valid, report_buttons, stick_x, stick_y, cstick_x, cstick_y,
                  reset_action, dequeued, coalesced, queue_fill, input ready);
  modport sink (input valid, report_buttons, stick_x, stick_y, cstick_x, cstick_y,
                reset_action, dequeued, coalesced, queue_fill, output ready);
endinterface

interface pcq_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] auto_release_mask;

  modport source (output valid, auto_release_mask, input ready);
  modport sink (input valid, auto_release_mask, output ready);
endinterface

### rtl/pcq_front.sv
// Front end: accepts items, builds the console report and the home action of a push.
// Depends on pcq_pkg and the interfaces in pcq_intf.sv.
module pcq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pcq_in_if.sink         in_i,
  pcq_cfg_if.sink        cfg_i,
  output pcq_pkg::cmd_t  cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import pcq_pkg::*;

  localparam logic [2:0] MaskReset = 3'd2;

  logic [2:0] mask_q;
  logic       home_prev_q;
  logic       home_prev_d;
  logic       home;
  logic       auto_rel;
  logic [3:0] mask_ext;
  action_e    action;
  logic       push_acc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign push_acc    = in_i.valid && cmd_ready_i && (opcode_e'(in_i.opcode) == OpPush);

  // Format three has no mask bit and reads as clear.
  assign mask_ext = {1'b0, mask_q};
  assign auto_rel = mask_ext[in_i.format_index];
  assign home     = in_i.pad_buttons[8];

  always_comb begin
    action      = ActNothing;
    home_prev_d = home_prev_q;
    if (home != home_prev_q) begin
      if (home) begin
        action      = ActPress;
        home_prev_d = 1'b1;
        if (auto_rel) begin
          // Rearm: the next held home sample counts as a fresh press.
          action      = ActPressRelease;
          home_prev_d = 1'b0;
        end
      end else begin
        action      = ActRelease;
        home_prev_d = 1'b0;
      end
    end
  end

  always_comb begin
    cmd_o.op                = opcode_e'(in_i.opcode);
    cmd_o.write_ok          = in_i.write_ok;
    cmd_o.action            = action;
    cmd_o.report.buttons    = {hat_dirs(in_i.hat), in_i.pad_buttons[7:0]};
    cmd_o.report.stick_x    = in_i.left_x;
    cmd_o.report.stick_y    = invert_axis(in_i.left_y);
    cmd_o.report.cstick_x   = in_i.right_x;
    cmd_o.report.cstick_y   = invert_axis(in_i.right_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= MaskReset;
      home_prev_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        mask_q <= cfg_i.auto_release_mask;
      end
      if (push_acc) begin
        home_prev_q <= home_prev_d;
      end
    end
  end

endmodule

### rtl/pcq_cmd_fifo.sv
// Two-entry command FIFO between the front and the back.
// Depends on pcq_pkg.
module pcq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pcq_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pcq_pkg::cmd_t pop_data_o
);
  import pcq_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/pcq_back.sv
// Back end: ring queue memory, coalescing, polls and the result register.
// Depends on pcq_pkg, pcq_intf.sv and the assertion macro header.
`include "pad_command_queue_with_coalescing_core_defines.svh"

module pcq_back #(
  parameter int unsigned QueueDepth = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcq_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  pcq_out_if.source     out_o
);
  import pcq_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  typedef struct packed {
    report_t    report;
    action_e    action;
    logic       dequeued;
    logic       coalesced;
    logic [6:0] fill;
  } result_t;

  entry_t mem [QueueDepth];
  entry_t rd_data_q;

  state_e          state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [PtrW-1:0] newest_ptr_q, newest_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  entry_t          newest_q, newest_d;
  report_t         last_sent_q, last_sent_d;
  logic            ok_q, ok_d;
  logic            out_valid_q, out_valid_d;
  result_t         res_q, res_d;

  logic            out_free;
  logic            full;
  logic            res_load;
  logic            mem_we;
  logic            mem_re;
  logic [PtrW-1:0] mem_waddr;
  entry_t          mem_wdata;
  entry_t          new_entry;
  entry_t          merged;
  logic [CntW+6:0] fill_ext;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !out_valid_q || out_o.ready;
  assign full     = (count_q == FullCnt);

  assign new_entry.action = cmd_i.action;
  assign new_entry.report = cmd_i.report;

  // Merge into the newest entry: OR buttons, take new axes, keep old action if none.
  always_comb begin
    merged                 = new_entry;
    merged.report.buttons  = newest_q.report.buttons | cmd_i.report.buttons;
    merged.action          = (cmd_i.action != ActNothing) ? cmd_i.action : newest_q.action;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    newest_ptr_d = newest_ptr_q;
    newest_d     = newest_q;
    count_d      = count_q;
    last_sent_d  = last_sent_q;
    ok_d         = ok_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    res_d        = res_q;
    res_load     = 1'b0;
    cmd_ready_o  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = tail_q;
    mem_wdata    = new_entry;

    unique case (state_q)
      StIdle: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          if (cmd_i.op == OpPush) begin
            mem_we = 1'b1;
            if (full) begin
              mem_waddr = newest_ptr_q;
              mem_wdata = merged;
              newest_d  = merged;
            end else begin
              tail_d       = ptr_inc(tail_q);
              newest_ptr_d = tail_q;
              newest_d     = new_entry;
              count_d      = count_q + 1'b1;
            end
            res_load        = 1'b1;
            res_d.report    = cmd_i.report;
            res_d.action    = ActNothing;
            res_d.dequeued  = 1'b0;
            res_d.coalesced = full;
          end else if (count_q == '0) begin
            res_load        = 1'b1;
            res_d.report    = last_sent_q;
            res_d.action    = ActNothing;
            res_d.dequeued  = 1'b0;
            res_d.coalesced = 1'b0;
          end else begin
            // Fetch the head; finish once the read data lands.
            mem_re  = 1'b1;
            ok_d    = cmd_i.write_ok;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        if (out_free) begin
          last_sent_d     = rd_data_q.report;
          res_load        = 1'b1;
          res_d.report    = rd_data_q.report;
          res_d.action    = ActNothing;
          res_d.dequeued  = 1'b0;
          res_d.coalesced = 1'b0;
          if (ok_q) begin
            head_d         = ptr_inc(head_q);
            count_d        = count_q - 1'b1;
            res_d.action   = rd_data_q.action;
            res_d.dequeued = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    fill_ext = {7'd0, count_d};
    if (res_load) begin
      res_d.fill  = fill_ext[6:0];
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= '0;
      tail_q       <= '0;
      newest_ptr_q <= '0;
      count_q      <= '0;
      newest_q     <= '0;
      last_sent_q  <= DefaultReport;
      ok_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      newest_ptr_q <= newest_ptr_d;
      count_q      <= count_d;
      newest_q     <= newest_d;
      last_sent_q  <= last_sent_d;
      ok_q         <= ok_d;
      out_valid_q  <= out_valid_d;
      res_q        <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.report_buttons = res_q.report.buttons;
  assign out_o.stick_x        = res_q.report.stick_x;
  assign out_o.stick_y        = res_q.report.stick_y;
  assign out_o.cstick_x       = res_q.report.cstick_x;
  assign out_o.cstick_y       = res_q.report.cstick_y;
  assign out_o.reset_action   = res_q.action;
  assign out_o.dequeued       = res_q.dequeued;
  assign out_o.coalesced      = res_q.coalesced;
  assign out_o.queue_fill     = res_q.fill;

  `PCQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FullCnt, "queue count above depth")
  `PCQ_ASSERT(a_empty_ptrs, clk_i, rst_ni, (count_q == '0) |-> (head_q == tail_q), "empty queue with head and tail apart")
  `PCQ_ASSERT(a_read_done, clk_i, rst_ni, ((state_q == StRead) && out_free) |=> out_valid_q, "head read did not produce a result")
  `PCQ_ASSERT_NEVER(a_deq_empty, clk_i, rst_ni, res_load && res_d.dequeued && (count_q == '0), "dequeue from empty queue")

endmodule

### rtl/pad_command_queue_with_coalescing_core.sv
// Channel  | Dir | Handshake     | Payload
// in_i     | in  | valid / ready | opcode, pad state, format_index, write_ok
// out_o    | out | valid / ready | console report, reset_action, flags, queue_fill
// cfg_i    | in  | valid / ready | auto_release_mask (always ready)
//
// A push or a poll of an empty queue ends in StIdle; a poll of a non-empty queue
// also passes StRead, set by the registered read port of the queue memory.
// Items enter a two-entry command FIFO, so the front accepts while the back works.
// Reset clears pointers and count, restores last report; no memory clear is needed.
// A result waiting in the output register stalls the back, then the FIFO, then in_i.
module pad_command_queue_with_coalescing_core #(
  parameter int unsigned QueueDepth = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcq_in_if.sink    in_i,
  pcq_cfg_if.sink   cfg_i,
  pcq_out_if.source out_o
);
  import pcq_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  pcq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  pcq_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  pcq_back #(
    .QueueDepth (QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule
